[src/fvn_pkg.sv]
// Shared types and constants for the fractal value noise block.
package fvn_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int OCT_STAGES = 10;

  localparam int HASH_KX    = 23;
  localparam int HASH_KY    = 57;
  localparam int HASH_KS    = 17;
  localparam int HASH_SHL   = 13;
  localparam logic [31:0] HASH_C1 = 32'd15731;
  localparam logic [31:0] HASH_C2 = 32'd789221;
  localparam logic [31:0] HASH_C3 = 32'd1376312589;

  localparam logic [23:0] FREQ_MAX = 24'hFFFFFF;
  localparam logic [38:0] AMP_MAX  = 39'h7FFFFFFFFF;

  typedef enum logic [2:0] {
    CFG_INIT_FREQ,
    CFG_INIT_AMP,
    CFG_FREQ_MULT,
    CFG_PERSIST,
    CFG_OCT_COUNT,
    CFG_SEED
  } cfg_idx_t;

  // per-item context handed from one octave to the next
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [23:0]        freq;
    logic [38:0]        amp;
    logic signed [39:0] sum;
    logic [38:0]        asum;
  } fvn_ctx_t;

endpackage

[src/fvn_octave.sv]
// One octave of the noise sum: split, corner hash, bilinear blend, weight, accumulate.
module fvn_octave
  import fvn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  fvn_ctx_t    in_ctx,
  input  logic        en,
  input  logic [31:0] seed17,
  input  logic [19:0] freq_mult,
  input  logic [16:0] persist,
  output logic        out_vld,
  output fvn_ctx_t    out_ctx
);

  localparam int NS = OCT_STAGES;

  logic [NS:1] vld_r;
  fvn_ctx_t    ctx_r [1:NS-1];
  fvn_ctx_t    out_ctx_r;

  logic signed [56:0] px_r, py_r;
  logic [43:0]        fp_r;
  logic [55:0]        ap_r;

  logic [31:0]        ix_r, iy_r;
  logic signed [16:0] fx_r [2:7];
  logic signed [16:0] fy_r [2:7];
  logic [23:0]        nf_r [2:9];
  logic [38:0]        na_r [2:9];

  logic [31:0]        m3_r [4];
  logic [31:0]        m4_r [4];
  logic [31:0]        mm_r [4];
  logic [31:0]        m5_r [4];
  logic [31:0]        t_r  [4];
  logic signed [17:0] c_r  [4];
  logic signed [20:0] lo_r, hi_r;
  logic signed [23:0] v_r;
  logic signed [47:0] w_r;

  // stage 1
  logic signed [56:0] px_nxt, py_nxt;
  logic [43:0]        fp_nxt;
  logic [55:0]        ap_nxt;
  // stage 2
  logic [56:0]        absx, absy;
  logic [31:0]        ix_nxt, iy_nxt;
  logic signed [16:0] fx_nxt, fy_nxt;
  logic [23:0]        nf_nxt;
  logic [38:0]        na_nxt;
  // stage 3
  logic [31:0]        base;
  logic [31:0]        mraw [4];
  logic [31:0]        m_nxt [4];
  // stage 4..6
  logic [31:0]        mm_nxt [4];
  logic [31:0]        t_nxt [4];
  logic [31:0]        h [4];
  logic signed [17:0] c_nxt [4];
  // stage 7..9
  logic signed [18:0] d_lo, d_hi;
  logic signed [35:0] p_lo, p_hi;
  logic signed [20:0] lo_nxt, hi_nxt;
  logic signed [21:0] d_v;
  logic signed [38:0] p_v;
  logic signed [23:0] v_nxt;
  logic signed [63:0] wp;
  logic signed [47:0] w_nxt;
  // stage 10
  logic signed [48:0] s_wide;
  logic [39:0]        a_wide;
  fvn_ctx_t           out_ctx_nxt;

  always_comb begin
    px_nxt = in_ctx.x * $signed({1'b0, in_ctx.freq});
    py_nxt = in_ctx.y * $signed({1'b0, in_ctx.freq});
    fp_nxt = 44'(in_ctx.freq) * 44'(freq_mult);
    ap_nxt = 56'(in_ctx.amp) * 56'(persist);
  end

  // truncate toward zero: work on magnitudes, then restore the sign
  always_comb begin
    absx   = px_r[56] ? 57'(-px_r) : 57'(px_r);
    absy   = py_r[56] ? 57'(-py_r) : 57'(py_r);
    ix_nxt = px_r[56] ? 32'(32'd0 - {8'd0, absx[2*FRAC_BITS +: 24]})
                      : {8'd0, absx[2*FRAC_BITS +: 24]};
    iy_nxt = py_r[56] ? 32'(32'd0 - {8'd0, absy[2*FRAC_BITS +: 24]})
                      : {8'd0, absy[2*FRAC_BITS +: 24]};
    fx_nxt = px_r[56] ? 17'(-$signed({1'b0, absx[FRAC_BITS +: FRAC_BITS]}))
                      : $signed({1'b0, absx[FRAC_BITS +: FRAC_BITS]});
    fy_nxt = py_r[56] ? 17'(-$signed({1'b0, absy[FRAC_BITS +: FRAC_BITS]}))
                      : $signed({1'b0, absy[FRAC_BITS +: FRAC_BITS]});
    nf_nxt = (|fp_r[43:40]) ? FREQ_MAX : fp_r[39:16];
    na_nxt = ap_r[55] ? AMP_MAX : ap_r[54:16];
  end

  // corner order: (0,0) (1,0) (0,1) (1,1)
  always_comb begin
    base = 32'(ix_r * 32'(HASH_KX)) + 32'(iy_r * 32'(HASH_KY)) + seed17;
    mraw[0] = base;
    mraw[1] = base + 32'(HASH_KX);
    mraw[2] = base + 32'(HASH_KY);
    mraw[3] = base + 32'(HASH_KX + HASH_KY);
    for (int i = 0; i < 4; i++) begin
      m_nxt[i]  = mraw[i] ^ (mraw[i] << HASH_SHL);
      mm_nxt[i] = 32'(m3_r[i] * m3_r[i]);
      t_nxt[i]  = 32'(mm_r[i] * HASH_C1) + HASH_C2;
      h[i]      = 32'(m5_r[i] * t_r[i]) + HASH_C3;
      c_nxt[i]  = $signed(18'(1 << FRAC_BITS)) - $signed({1'b0, h[i][30:30-FRAC_BITS]});
    end
  end

  always_comb begin
    d_lo   = 19'(c_r[1]) - 19'(c_r[0]);
    d_hi   = 19'(c_r[3]) - 19'(c_r[2]);
    p_lo   = d_lo * fx_r[6];
    p_hi   = d_hi * fx_r[6];
    lo_nxt = 21'(c_r[0]) + 21'(p_lo >>> FRAC_BITS);
    hi_nxt = 21'(c_r[2]) + 21'(p_hi >>> FRAC_BITS);
    d_v    = 22'(hi_r) - 22'(lo_r);
    p_v    = d_v * fy_r[7];
    v_nxt  = 24'(lo_r) + 24'(p_v >>> FRAC_BITS);
    wp     = v_r * $signed({1'b0, ctx_r[8].amp});
    w_nxt  = wp[63:FRAC_BITS];
  end

  always_comb begin
    out_ctx_nxt      = ctx_r[9];
    out_ctx_nxt.freq = nf_r[9];
    out_ctx_nxt.amp  = na_r[9];
    s_wide = 49'(ctx_r[9].sum) + 49'(w_r);
    a_wide = 40'(ctx_r[9].asum) + 40'(ctx_r[9].amp);
    if (en) begin
      if (s_wide > 49'sh7FFFFFFFFF) begin
        out_ctx_nxt.sum = 40'sh7FFFFFFFFF;
      end else if (s_wide < -49'sh8000000000) begin
        out_ctx_nxt.sum = 40'sh8000000000;
      end else begin
        out_ctx_nxt.sum = s_wide[39:0];
      end
      out_ctx_nxt.asum = a_wide[39] ? AMP_MAX : a_wide[38:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NS-1:1], in_vld};
    end
    ctx_r[1] <= in_ctx;
    for (int s = 2; s < NS; s++) ctx_r[s] <= ctx_r[s-1];
    px_r <= px_nxt;
    py_r <= py_nxt;
    fp_r <= fp_nxt;
    ap_r <= ap_nxt;
    ix_r <= ix_nxt;
    iy_r <= iy_nxt;
    fx_r[2] <= fx_nxt;
    fy_r[2] <= fy_nxt;
    for (int s = 3; s <= 7; s++) begin
      fx_r[s] <= fx_r[s-1];
      fy_r[s] <= fy_r[s-1];
    end
    nf_r[2] <= nf_nxt;
    na_r[2] <= na_nxt;
    for (int s = 3; s <= 9; s++) begin
      nf_r[s] <= nf_r[s-1];
      na_r[s] <= na_r[s-1];
    end
    for (int i = 0; i < 4; i++) begin
      m3_r[i] <= m_nxt[i];
      mm_r[i] <= mm_nxt[i];
      m4_r[i] <= m3_r[i];
      m5_r[i] <= m4_r[i];
      t_r[i]  <= t_nxt[i];
      c_r[i]  <= c_nxt[i];
    end
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    v_r       <= v_nxt;
    w_r       <= w_nxt;
    out_ctx_r <= out_ctx_nxt;
  end

  assign out_vld = vld_r[NS];
  assign out_ctx = out_ctx_r;

`ifndef SYNTHESIS
  a_vld_latency: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NS] |-> $past(in_vld, NS))
    else $error("octave valid without matching input");
  a_asum_grows: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NS] |-> out_ctx_r.asum >= $past(ctx_r[NS-1].asum))
    else $error("amplitude sum decreased");
`endif

endmodule

[src/fractal_value_noise_2d.sv]
// Top level: configuration registers and the chain of octave pipelines.
// Takes one coordinate per cycle (busy stays low). Each result reaches the
// result ports in order, after the input register and the pipeline of every
// octave. There is one input register plus a ten-stage pipeline per octave:
// coordinate scale, split, corner hash over four stages (mix, then three
// multiplies), two blend stages, weight, accumulate. All MAX_OCTAVES of them
// always run, disabled octaves adding nothing.
// Results appear for one cycle on out_valid and must be taken then.
module fractal_value_noise_2d
  import fvn_pkg::*;
#(
  parameter int MAX_OCTAVES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               out_valid,
  output logic signed [39:0] out_noise_sum,
  output logic [38:0]        out_amplitude_sum
);

  localparam int LAT = 1 + OCT_STAGES * MAX_OCTAVES;

  logic [23:0] init_freq_r;
  logic [19:0] init_amp_r;
  logic [19:0] freq_mult_r;
  logic [16:0] persist_r;
  logic [3:0]  oct_count_r;
  logic [31:0] seed_r;
  logic [31:0] seed17;

  logic        vld0_r;
  fvn_ctx_t    ctx0_r;
  fvn_ctx_t    ctx0_nxt;

  logic        vld_c [0:MAX_OCTAVES];
  fvn_ctx_t    ctx_c [0:MAX_OCTAVES];

  assign busy   = 1'b0;
  assign seed17 = 32'(seed_r * 32'(HASH_KS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_freq_r <= 24'd65536;
      init_amp_r  <= 20'd65536;
      freq_mult_r <= 20'd131072;
      persist_r   <= 17'd32768;
      oct_count_r <= 4'd1;
      seed_r      <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_INIT_FREQ: init_freq_r <= cfg_data[23:0];
        CFG_INIT_AMP:  init_amp_r  <= cfg_data[19:0];
        CFG_FREQ_MULT: freq_mult_r <= cfg_data[19:0];
        CFG_PERSIST:   persist_r   <= cfg_data[16:0];
        CFG_OCT_COUNT: oct_count_r <= cfg_data[3:0];
        CFG_SEED:      seed_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    ctx0_nxt.x    = in_coord_x;
    ctx0_nxt.y    = in_coord_y;
    ctx0_nxt.freq = init_freq_r;
    ctx0_nxt.amp  = 39'(init_amp_r);
    ctx0_nxt.sum  = '0;
    ctx0_nxt.asum = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= start && !busy;
    end
    ctx0_r <= ctx0_nxt;
  end

  assign vld_c[0] = vld0_r;
  assign ctx_c[0] = ctx0_r;

  // counts above MAX_OCTAVES simply enable every stage
  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
    fvn_octave u_oct (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_vld    (vld_c[k]),
      .in_ctx    (ctx_c[k]),
      .en        (5'(k) < {1'b0, oct_count_r}),
      .seed17    (seed17),
      .freq_mult (freq_mult_r),
      .persist   (persist_r),
      .out_vld   (vld_c[k+1]),
      .out_ctx   (ctx_c[k+1])
    );
  end

  assign out_valid         = vld_c[MAX_OCTAVES];
  assign out_noise_sum     = ctx_c[MAX_OCTAVES].sum;
  assign out_amplitude_sum = ctx_c[MAX_OCTAVES].asum;

`ifndef SYNTHESIS
  a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without accepted transaction");
`endif

endmodule
